### rtl/tssf_pkg.sv
// Shared types and constants for the TCP SYN+ACK source filter.
// Used by the parser, the table cells and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tssf_pkg;

   // table geometry
   localparam int TABLE_SLOTS_DEFAULT = 64;
   localparam int SLOT_W              = 6;

   // request kinds
   localparam logic REQ_FRAME_BYTE  = 1'b0;
   localparam logic REQ_ENTRY_WRITE = 1'b1;

   // verdict codes
   localparam logic [1:0] VERDICT_NONE    = 2'd0;
   localparam logic [1:0] VERDICT_PASSED  = 2'd1;
   localparam logic [1:0] VERDICT_BLOCKED = 2'd2;

   // protocol constants
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  SYN_ACK_MASK   = 8'h12;
   localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
   localparam logic [15:0] TCP_FLAGS_AT   = 16'd13;
   localparam logic [15:0] TCP_HDR_LEN    = 16'd20;
   localparam logic [3:0]  IP_MIN_WORDS   = 4'd5;
   localparam logic [15:0] OFFSET_MAX     = 16'hFFFF;

   typedef struct packed {
      logic              req_type;
      logic [7:0]        frame_byte;
      logic              frame_end;
      logic [SLOT_W-1:0] entry_slot;
      logic              entry_enable;
      logic [31:0]       entry_address;
      logic [15:0]       entry_port;
   } req_item_type;

   typedef struct packed {
      logic        drop_frame;
      logic [1:0]  verdict_class;
      logic [63:0] passed_total;
      logic [63:0] blocked_total;
   } rsp_item_type;

   // item travelling down the cell chain: a lookup or a table write
   typedef struct packed {
      logic              valid;
      logic              is_entry;
      logic              qualify;
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic              enable;
      logic [31:0]       address;
      logic [15:0]       port;
   } chain_item_type;

endpackage

`default_nettype wire

### rtl/tssf_parser.sv
// Byte-serial Ethernet/IPv4/TCP header parser; emits one chain item per
// frame end or table write. Depends on tssf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tssf_parser import tssf_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           take,
   input  wire req_item_type   req,
   output chain_item_type      item
);

   logic [15:0] offset_ff, offset_in;
   logic [15:0] ether_ff, ether_in;
   logic [3:0]  words_ff, words_in;
   logic [7:0]  proto_ff, proto_in;
   logic [31:0] addr_ff, addr_in;
   logic [15:0] port_ff, port_in;
   logic [7:0]  flags_ff, flags_in;

   logic [15:0] tcp_start;
   logic [15:0] rel;
   logic [15:0] min_len;
   logic        is_byte;
   logic        qualify;
   logic [7:0]  b;

   // per-byte field capture, frame verdict and chain item
   always_comb begin
      offset_in = offset_ff;
      ether_in  = ether_ff;
      words_in  = words_ff;
      proto_in  = proto_ff;
      addr_in   = addr_ff;
      port_in   = port_ff;
      flags_in  = flags_ff;
      b         = req.frame_byte;
      tcp_start = ETH_HDR_LEN + {10'd0, words_ff, 2'b00};
      rel       = offset_ff - tcp_start;
      is_byte   = take && (req.req_type == REQ_FRAME_BYTE);

      if (is_byte && (offset_ff != OFFSET_MAX)) begin
         if ((offset_ff == 16'd12) || (offset_ff == 16'd13)) begin
            ether_in = {ether_ff[7:0], b};
         end else if (offset_ff == ETH_HDR_LEN) begin
            words_in = b[3:0];
         end else if (offset_ff == ETH_HDR_LEN + 16'd9) begin
            proto_in = b;
         end else if ((offset_ff >= ETH_HDR_LEN + 16'd12) &&
                      (offset_ff <= ETH_HDR_LEN + 16'd15)) begin
            addr_in = {addr_ff[23:0], b};
         end
         if ((offset_ff > ETH_HDR_LEN) && (offset_ff >= tcp_start)) begin
            if ((rel == 16'd0) || (rel == 16'd1)) begin
               port_in = {port_ff[7:0], b};
            end else if (rel == TCP_FLAGS_AT) begin
               flags_in = b;
            end
         end
         offset_in = offset_ff + 16'd1;
      end

      // qualifying frame: IPv4, TCP, full headers present, SYN and ACK set
      min_len = ETH_HDR_LEN + {10'd0, words_in, 2'b00} + TCP_HDR_LEN;
      qualify = (ether_in == ETHERTYPE_IPV4) && (words_in >= IP_MIN_WORDS) &&
                (proto_in == PROTO_TCP) && (offset_in >= min_len) &&
                ((flags_in & SYN_ACK_MASK) == SYN_ACK_MASK);

      item = '0;
      if (take && (req.req_type == REQ_ENTRY_WRITE)) begin
         item.valid    = 1'b1;
         item.is_entry = 1'b1;
         item.slot     = req.entry_slot;
         item.enable   = req.entry_enable;
         item.address  = req.entry_address;
         item.port     = req.entry_port;
      end else if (is_byte && req.frame_end) begin
         item.valid   = 1'b1;
         item.qualify = qualify;
         item.address = addr_in;
         item.port    = port_in;
      end

      // start the next frame from scratch
      if (is_byte && req.frame_end) begin
         offset_in = '0;
         ether_in  = '0;
         words_in  = '0;
         proto_in  = '0;
         addr_in   = '0;
         port_in   = '0;
         flags_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         ether_ff  <= '0;
         words_ff  <= '0;
         proto_ff  <= '0;
         addr_ff   <= '0;
         port_ff   <= '0;
         flags_ff  <= '0;
      end else begin
         offset_ff <= offset_in;
         ether_ff  <= ether_in;
         words_ff  <= words_in;
         proto_ff  <= proto_in;
         addr_ff   <= addr_in;
         port_ff   <= port_in;
         flags_ff  <= flags_in;
      end
   end

endmodule

`default_nettype wire

### rtl/tssf_cell.sv
// One filter table slot: holds an (address, port) entry and passes chain
// items to its neighbor, updating or matching on the way. Depends on tssf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tssf_cell import tssf_pkg::*; #(
   parameter int CELL_INDEX = 0
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           advance,
   input  wire chain_item_type prev_item,
   output chain_item_type      item_out
);

   logic           active_ff;
   logic [31:0]    address_ff;
   logic [15:0]    port_ff;
   chain_item_type item_ff, item_in;
   logic           slot_hit;
   logic           match;

   // table write aimed at this slot, or a lookup hitting this entry
   always_comb begin
      slot_hit = prev_item.valid && prev_item.is_entry &&
                 (32'(prev_item.slot) == CELL_INDEX);
      match    = prev_item.valid && !prev_item.is_entry && active_ff &&
                 (address_ff == prev_item.address) && (port_ff == prev_item.port);
      item_in     = prev_item;
      item_in.hit = prev_item.hit | match;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         item_ff   <= '0;
      end else if (advance) begin
         item_ff <= item_in;
         if (slot_hit) begin
            active_ff <= prev_item.enable;
         end
      end
   end

   // entry contents: undefined until written
   always_ff @(posedge clock) begin
      if (advance && slot_hit) begin
         address_ff <= prev_item.address;
         port_ff    <= prev_item.port;
      end
   end

   assign item_out = item_ff;

endmodule

`default_nettype wire

### rtl/tcp_synack_source_filter_unit.sv
// Top level of the TCP SYN+ACK source filter: parser, a chain of table
// cells and the verdict/counter stage. Depends on tssf_pkg, tssf_parser, tssf_cell.
`timescale 1ns / 1ps
`default_nettype none

// Takes one item per cycle: a frame byte or a table entry write. The frame
// end byte turns into a lookup that walks the chain of TABLE_SLOTS cells, one
// cell per cycle, behind and ahead of table writes in arrival order, so every
// lookup sees the table exactly as written before its frame ended. A result
// appears once the lookup has left the last of the TABLE_SLOTS cell registers
// and passed the output register; the chain length sets that delay. Throughput
// is one item per cycle while results are taken; the whole chain holds while
// a result waits in the output register and rsp_ready is low. Slot valid marks
// clear at reset at once, so there is no clearing pass.
module tcp_synack_source_filter_unit import tssf_pkg::*; #(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_item_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_item_type      rsp_data
);

   logic           advance;
   logic           req_take;
   chain_item_type link [TABLE_SLOTS+1];
   chain_item_type tail;
   logic           tail_query;

   logic [63:0]    pass_ff, pass_in;
   logic [63:0]    block_ff, block_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_item_type   rsp_data_ff, rsp_data_in;

   // chain moves whenever the output register is free or being emptied
   assign advance  = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign req_take  = req_valid && advance;

   tssf_parser u_parser (
      .clock (clock),
      .reset (reset),
      .take  (req_take),
      .req   (req_data),
      .item  (link[0])
   );

   // row of table cells
   for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
      tssf_cell #(
         .CELL_INDEX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .prev_item (link[i]),
         .item_out  (link[i+1])
      );
   end

   assign tail       = link[TABLE_SLOTS];
   assign tail_query = tail.valid && !tail.is_entry;

   // verdict and counters at the end of the chain
   always_comb begin
      pass_in      = pass_ff;
      block_in     = block_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = tail_query;
         if (tail_query) begin
            rsp_data_in.drop_frame    = 1'b0;
            rsp_data_in.verdict_class = VERDICT_NONE;
            if (tail.qualify) begin
               if (tail.hit) begin
                  block_in                  = block_ff + 64'd1;
                  rsp_data_in.drop_frame    = 1'b1;
                  rsp_data_in.verdict_class = VERDICT_BLOCKED;
               end else begin
                  pass_in                   = pass_ff + 64'd1;
                  rsp_data_in.verdict_class = VERDICT_PASSED;
               end
            end
            rsp_data_in.passed_total  = pass_in;
            rsp_data_in.blocked_total = block_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff      <= '0;
         block_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pass_ff      <= pass_in;
         block_ff     <= block_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a qualifying lookup leaving the chain bumps exactly one counter
   a_one_count: assert property (@(posedge clock) disable iff (reset)
      advance && tail_query && tail.qualify |=>
         (pass_ff + block_ff) == ($past(pass_ff + block_ff) + 64'd1))
      else $error("qualifying frame did not advance exactly one counter");

   // drop flag agrees with the verdict class
   a_drop_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.drop_frame == (rsp_data.verdict_class == VERDICT_BLOCKED)))
      else $error("drop flag disagrees with verdict class");

   // no stale result survives reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for tcp_synack_source_filter_unit: frames built
// byte by byte, directed then random, checked against a local filter predictor.
// Depends on tssf_pkg and the RTL of the unit only.
`timescale 1ns / 1ps

module testbench;
   import tssf_pkg::*;

   localparam int SLOTS         = TABLE_SLOTS_DEFAULT;
   localparam int CHAIN_LATENCY = SLOTS + 2;
   localparam int RANDOM_ITEMS  = 700;
   localparam int RANDOM_FRAMES = 8;
   localparam int LONG_HOLD     = 400;
   localparam int POOL_SIZE     = 6;

   localparam logic [31:0] ADDR_A = 32'hC0A8_0101;
   localparam logic [15:0] PORT_A = 16'h01BB;

   typedef enum logic {ROW_ENTRY, ROW_FRAME} row_kind_type;

   // one directed step: a table write, or a whole frame with its known verdict
   typedef struct packed {
      row_kind_type      kind;
      logic [SLOT_W-1:0] slot;
      logic              enable;
      logic [31:0]       addr;
      logic [15:0]       port;
      logic [15:0]       etype;
      logic [7:0]        vihl;
      logic [7:0]        proto;
      logic [7:0]        flags;
      logic [31:0]       len;
      logic              mid_write;
      logic [1:0]        verdict;
   } row_type;

   localparam row_type DIRECTED_ROWS [24] = '{
      // not IPv4 right after reset
      '{ROW_FRAME, 6'd0, 1'b0, ADDR_A, PORT_A, 16'h86DD, 8'h45, PROTO_TCP, SYN_ACK_MASK,
        32'd60, 1'b0, VERDICT_NONE},
      // shortest qualifying frame, empty table
      '{ROW_FRAME, 6'd0, 1'b0, ADDR_A, PORT_A, ETHERTYPE_IPV4, 8'h45, PROTO_TCP,
        SYN_ACK_MASK, 32'd54, 1'b0, VERDICT_PASSED},
      // one byte short, then a single-byte frame
      '{ROW_FRAME, 6'd0, 1'b0, ADDR_A, PORT_A, ETHERTYPE_IPV4, 8'h45, PROTO_TCP,
        SYN_ACK_MASK, 32'd53, 1'b0, VERDICT_NONE},
      '{ROW_FRAME, 6'd0, 1'b0, ADDR_A, PORT_A, ETHERTYPE_IPV4, 8'h45, PROTO_TCP,
        SYN_ACK_MASK, 32'd1, 1'b0, VERDICT_NONE},
      '{ROW_ENTRY, 6'd0, 1'b1, ADDR_A, PORT_A, 16'h0, 8'h0, 8'h0, 8'h0, 32'd0, 1'b0,
        VERDICT_NONE},
      '{ROW_FRAME, 6'd0, 1'b0, ADDR_A, PORT_A, ETHERTYPE_IPV4, 8'h45, PROTO_TCP,
        SYN_ACK_MASK, 32'd54, 1'b0, VERDICT_BLOCKED},
      // SYN only, all flags, ACK only
      '{ROW_FRAME, 6'd0, 1'b0, ADDR_A, PORT_A, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'h02,
        32'd54, 1'b0, VERDICT_NONE},
      '{ROW_FRAME, 6'd0, 1'b0, ADDR_A, PORT_A, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'hFF,
        32'd54, 1'b0, VERDICT_BLOCKED},
      '{ROW_FRAME, 6'd0, 1'b0, ADDR_A, PORT_A, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'h10,
        32'd54, 1'b0, VERDICT_NONE},
      // UDP
      '{ROW_FRAME, 6'd0, 1'b0, ADDR_A, PORT_A, ETHERTYPE_IPV4, 8'h45, 8'd17, SYN_ACK_MASK,
        32'd54, 1'b0, VERDICT_NONE},
      // IHL below five, IHL zero
      '{ROW_FRAME, 6'd0, 1'b0, ADDR_A, PORT_A, ETHERTYPE_IPV4, 8'h44, PROTO_TCP,
        SYN_ACK_MASK, 32'd60, 1'b0, VERDICT_NONE},
      '{ROW_FRAME, 6'd0, 1'b0, ADDR_A, PORT_A, ETHERTYPE_IPV4, 8'h00, PROTO_TCP,
        SYN_ACK_MASK, 32'd60, 1'b0, VERDICT_NONE},
      // largest IHL at its exact minimum length
      '{ROW_FRAME, 6'd0, 1'b0, ADDR_A, PORT_A, ETHERTYPE_IPV4, 8'h4F, PROTO_TCP,
        SYN_ACK_MASK, 32'd94, 1'b0, VERDICT_BLOCKED},
      // version nibble ignored; port differs so no match
      '{ROW_FRAME, 6'd0, 1'b0, ADDR_A, 16'h01BC, ETHERTYPE_IPV4, 8'hF5, PROTO_TCP,
        SYN_ACK_MASK, 32'd54, 1'b0, VERDICT_PASSED},
      // top slot, all-ones key; then removed
      '{ROW_ENTRY, 6'd63, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'h0, 8'h0, 8'h0, 8'h0, 32'd0,
        1'b0, VERDICT_NONE},
      '{ROW_FRAME, 6'd0, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, ETHERTYPE_IPV4, 8'h45, PROTO_TCP,
        SYN_ACK_MASK, 32'd54, 1'b0, VERDICT_BLOCKED},
      '{ROW_ENTRY, 6'd63, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, 16'h0, 8'h0, 8'h0, 8'h0, 32'd0,
        1'b0, VERDICT_NONE},
      '{ROW_FRAME, 6'd0, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, ETHERTYPE_IPV4, 8'h45, PROTO_TCP,
        SYN_ACK_MASK, 32'd54, 1'b0, VERDICT_PASSED},
      // duplicate key in slot 5, slot 0 removed: still blocked
      '{ROW_ENTRY, 6'd5, 1'b1, ADDR_A, PORT_A, 16'h0, 8'h0, 8'h0, 8'h0, 32'd0, 1'b0,
        VERDICT_NONE},
      '{ROW_ENTRY, 6'd0, 1'b0, ADDR_A, PORT_A, 16'h0, 8'h0, 8'h0, 8'h0, 32'd0, 1'b0,
        VERDICT_NONE},
      '{ROW_FRAME, 6'd0, 1'b0, ADDR_A, PORT_A, ETHERTYPE_IPV4, 8'h45, PROTO_TCP,
        SYN_ACK_MASK, 32'd54, 1'b0, VERDICT_BLOCKED},
      // zero key written in the middle of the frame it then blocks
      '{ROW_FRAME, 6'd7, 1'b1, 32'h0, 16'h0, ETHERTYPE_IPV4, 8'h45, PROTO_TCP,
        SYN_ACK_MASK, 32'd54, 1'b1, VERDICT_BLOCKED},
      // long frame from a source nobody listed
      '{ROW_FRAME, 6'd0, 1'b0, 32'h1234_5678, 16'h0, ETHERTYPE_IPV4, 8'h45, PROTO_TCP,
        SYN_ACK_MASK, 32'd300, 1'b0, VERDICT_PASSED},
      '{ROW_FRAME, 6'd0, 1'b0, ADDR_A, PORT_A, ETHERTYPE_IPV4, 8'h4F, PROTO_TCP,
        SYN_ACK_MASK, 32'd93, 1'b0, VERDICT_NONE}
   };

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   req_item_type req_data  = '0;
   logic         req_ready;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_data;

   // predictor state: frame parser, filter table, counters
   logic [15:0] parse_offset;
   logic [15:0] parse_etype;
   logic [3:0]  parse_words;
   logic [7:0]  parse_proto;
   logic [31:0] parse_addr;
   logic [15:0] parse_port;
   logic [7:0]  parse_flags;
   bit          slot_live [SLOTS];
   logic [31:0] slot_addr [SLOTS];
   logic [15:0] slot_port [SLOTS];
   logic [63:0] passed_count;
   logic [63:0] blocked_count;

   rsp_item_type expected_verdicts [$];

   int mismatch_count = 0;
   int results_seen   = 0;
   int items_sent     = 0;
   int entries_sent   = 0;
   int burst_left     = 0;
   int input_stalls   = 0;
   int verdict_tally [3] = '{0, 0, 0};

   tcp_synack_source_filter_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("testbench: errors");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
   endtask

   // Advance the filter predictor by one item; returns 1 with the verdict
   // when the item ends a frame.
   function automatic bit judge_item(input req_item_type it, output rsp_item_type verdict);
      logic [15:0] pos;
      int unsigned tcp_start;
      int unsigned rel;
      int unsigned min_len;
      bit          hit;
      verdict = '0;
      if (it.req_type == REQ_ENTRY_WRITE) begin
         if (it.entry_slot < SLOTS) begin
            slot_live[it.entry_slot] = it.entry_enable;
            slot_addr[it.entry_slot] = it.entry_address;
            slot_port[it.entry_slot] = it.entry_port;
         end
         return 1'b0;
      end

      // header field capture by byte position
      pos = parse_offset;
      if (pos < OFFSET_MAX) begin
         tcp_start = ETH_HDR_LEN + 4 * parse_words;
         if (pos == 12 || pos == 13)
            parse_etype = {parse_etype[7:0], it.frame_byte};
         else if (pos == ETH_HDR_LEN)
            parse_words = it.frame_byte[3:0];
         else if (pos == ETH_HDR_LEN + 9)
            parse_proto = it.frame_byte;
         else if (pos >= ETH_HDR_LEN + 12 && pos <= ETH_HDR_LEN + 15)
            parse_addr = {parse_addr[23:0], it.frame_byte};
         if (pos > ETH_HDR_LEN && pos >= tcp_start) begin
            rel = pos - tcp_start;
            if (rel <= 1)
               parse_port = {parse_port[7:0], it.frame_byte};
            else if (rel == TCP_FLAGS_AT)
               parse_flags = it.frame_byte;
         end
         parse_offset = pos + 16'd1;
      end
      if (!it.frame_end)
         return 1'b0;

      // verdict at the last byte
      min_len = ETH_HDR_LEN + 4 * parse_words + TCP_HDR_LEN;
      verdict.verdict_class = VERDICT_NONE;
      if (parse_etype == ETHERTYPE_IPV4 && parse_words >= IP_MIN_WORDS &&
          parse_proto == PROTO_TCP && parse_offset >= min_len &&
          (parse_flags & SYN_ACK_MASK) == SYN_ACK_MASK) begin
         hit = 1'b0;
         for (int s = 0; s < SLOTS; s++)
            if (slot_live[s] && slot_addr[s] == parse_addr && slot_port[s] == parse_port)
               hit = 1'b1;
         if (hit) begin
            blocked_count++;
            verdict.drop_frame    = 1'b1;
            verdict.verdict_class = VERDICT_BLOCKED;
         end else begin
            passed_count++;
            verdict.verdict_class = VERDICT_PASSED;
         end
      end
      verdict.passed_total  = passed_count;
      verdict.blocked_total = blocked_count;
      parse_offset = '0;
      parse_etype  = '0;
      parse_words  = '0;
      parse_proto  = '0;
      parse_addr   = '0;
      parse_port   = '0;
      parse_flags  = '0;
      return 1'b1;
   endfunction

   // Table write item; frame fields carry noise the block must ignore.
   function automatic req_item_type entry_item(input logic [SLOT_W-1:0] slot,
                                               input logic enable,
                                               input logic [31:0] addr,
                                               input logic [15:0] port);
      req_item_type it;
      it               = '0;
      it.req_type      = REQ_ENTRY_WRITE;
      it.frame_byte    = 8'($urandom);
      it.frame_end     = 1'($urandom);
      it.entry_slot    = slot;
      it.entry_enable  = enable;
      it.entry_address = addr;
      it.entry_port    = port;
      return it;
   endfunction

   // Offer one item in bursts with random gaps; predict once accepted.
   task automatic send_item(input req_item_type it, input bit use_typed,
                            input logic [1:0] typed_verdict);
      rsp_item_type verdict;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                  : $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      items_sent++;
      if (it.req_type == REQ_ENTRY_WRITE)
         entries_sent++;
      if (judge_item(it, verdict)) begin
         if (use_typed) begin
            verdict.verdict_class = typed_verdict;
            verdict.drop_frame    = (typed_verdict == VERDICT_BLOCKED);
         end
         expected_verdicts.push_back(verdict);
      end
   endtask

   // Build an Ethernet/IPv4/TCP frame around the given fields and send it,
   // optionally with a table write slipped in before some byte.
   task automatic send_frame(input logic [15:0] etype, input logic [7:0] vihl,
                             input logic [7:0] proto, input logic [7:0] flags,
                             input logic [31:0] addr, input logic [15:0] port,
                             input int unsigned len, input bit mid_write,
                             input req_item_type entry, input bit use_typed,
                             input logic [1:0] typed_verdict);
      logic [7:0]   bytes_q [$];
      int unsigned  tcp_start;
      int unsigned  fill_len;
      int           split_at;
      req_item_type it;
      tcp_start = ETH_HDR_LEN + 4 * vihl[3:0];
      fill_len  = (len > tcp_start + TCP_HDR_LEN) ? len : tcp_start + TCP_HDR_LEN;
      for (int i = 0; i < fill_len; i++)
         bytes_q.push_back(8'($urandom));
      // TCP fields first so IP fields win where a tiny IHL overlaps them
      bytes_q[tcp_start]                = port[15:8];
      bytes_q[tcp_start + 1]            = port[7:0];
      bytes_q[tcp_start + TCP_FLAGS_AT] = flags;
      bytes_q[12] = etype[15:8];
      bytes_q[13] = etype[7:0];
      bytes_q[14] = vihl;
      bytes_q[23] = proto;
      for (int j = 0; j < 4; j++)
         bytes_q[26 + j] = addr[31 - 8 * j -: 8];
      bytes_q  = bytes_q[0:len-1];
      split_at = mid_write ? $urandom_range(0, len - 1) : -1;

      for (int i = 0; i < len; i++) begin
         if (i == split_at)
            send_item(entry, 1'b0, VERDICT_NONE);
         it               = '0;
         it.req_type      = REQ_FRAME_BYTE;
         it.frame_byte    = bytes_q[i];
         it.frame_end     = (i == len - 1);
         it.entry_slot    = SLOT_W'($urandom);
         it.entry_enable  = 1'($urandom);
         it.entry_address = $urandom;
         it.entry_port    = 16'($urandom);
         send_item(it, use_typed && (i == len - 1), typed_verdict);
      end
   endtask

   task automatic check_result(input rsp_item_type got);
      rsp_item_type want;
      if (expected_verdicts.size() == 0) begin
         report_mismatch($sformatf("result with nothing expected: class %0d drop %0d",
                                   got.verdict_class, got.drop_frame));
         return;
      end
      want = expected_verdicts.pop_front();
      results_seen++;
      if (want.verdict_class <= VERDICT_BLOCKED)
         verdict_tally[want.verdict_class]++;
      if (got.drop_frame !== want.drop_frame)
         report_mismatch($sformatf("result %0d drop_frame %0d, expected %0d",
                                   results_seen, got.drop_frame, want.drop_frame));
      if (got.verdict_class !== want.verdict_class)
         report_mismatch($sformatf("result %0d verdict_class %0d, expected %0d",
                                   results_seen, got.verdict_class, want.verdict_class));
      if (got.passed_total !== want.passed_total)
         report_mismatch($sformatf("result %0d passed_total %0d, expected %0d",
                                   results_seen, got.passed_total, want.passed_total));
      if (got.blocked_total !== want.blocked_total)
         report_mismatch($sformatf("result %0d blocked_total %0d, expected %0d",
                                   results_seen, got.blocked_total, want.blocked_total));
   endtask

   // Receiver: check accepted results, stall in modes, one long hold-off.
   initial begin : receiver
      int mode;
      int mode_left;
      int hold_left;
      bit hold_done;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            check_result(rsp_data);
         if (hold_left > 0) begin
            if (req_valid && !req_ready)
               input_stalls++;
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && results_seen >= 10) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 2);
               mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= ($urandom_range(0, 2) == 0);
            endcase
         end
      end
   end

   // Sender: reset, directed rows, then random frames and table writes.
   initial begin : stimulus
      row_type      row;
      req_item_type rnd_entry;
      logic [31:0]  pool_addr [POOL_SIZE];
      logic [15:0]  pool_port [POOL_SIZE];
      logic [15:0]  etype;
      logic [7:0]   vihl;
      logic [7:0]   proto;
      logic [7:0]   flags;
      logic [31:0]  addr;
      logic [15:0]  port;
      int unsigned  ihl;
      int unsigned  len;
      int unsigned  min_len;
      int           p;
      int           start_items;
      int           random_frames;
      int           wait_cycles;

      parse_offset  = '0;
      parse_etype   = '0;
      parse_words   = '0;
      parse_proto   = '0;
      parse_addr    = '0;
      parse_port    = '0;
      parse_flags   = '0;
      passed_count  = '0;
      blocked_count = '0;
      for (int s = 0; s < SLOTS; s++) begin
         slot_live[s] = 1'b0;
         slot_addr[s] = '0;
         slot_port[s] = '0;
      end
      for (int k = 0; k < POOL_SIZE; k++) begin
         pool_addr[k] = $urandom;
         pool_port[k] = 16'($urandom);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_ROWS[i]) begin
         row = DIRECTED_ROWS[i];
         if (row.kind == ROW_ENTRY)
            send_item(entry_item(row.slot, row.enable, row.addr, row.port), 1'b0,
                      VERDICT_NONE);
         else
            send_frame(row.etype, row.vihl, row.proto, row.flags, row.addr, row.port,
                       row.len, row.mid_write,
                       entry_item(row.slot, row.enable, row.addr, row.port),
                       1'b1, row.verdict);
      end

      // random: mostly well-formed SYN+ACK frames keyed from a small pool
      start_items   = items_sent;
      random_frames = 0;
      while (items_sent - start_items < RANDOM_ITEMS || random_frames < RANDOM_FRAMES) begin
         p = $urandom_range(0, POOL_SIZE - 1);
         if ($urandom_range(0, 9) < 7)
            rnd_entry = entry_item(SLOT_W'($urandom), $urandom_range(0, 4) != 0,
                                   pool_addr[p], pool_port[p]);
         else
            rnd_entry = entry_item(SLOT_W'($urandom), $urandom_range(0, 4) != 0,
                                   $urandom, 16'($urandom));

         if ($urandom_range(0, 99) < 15) begin
            send_item(rnd_entry, 1'b0, VERDICT_NONE);
         end else begin
            p = $urandom_range(0, POOL_SIZE - 1);
            if ($urandom_range(0, 9) < 6) begin
               addr = pool_addr[p];
               port = pool_port[p];
            end else begin
               addr = $urandom;
               port = 16'($urandom);
            end
            etype   = ETHERTYPE_IPV4;
            ihl     = ($urandom_range(0, 3) != 0) ? 5 : $urandom_range(5, 15);
            vihl    = {4'($urandom), 4'(ihl)};
            proto   = PROTO_TCP;
            flags   = ($urandom_range(0, 4) != 0) ? (8'($urandom) | SYN_ACK_MASK)
                                                  : 8'($urandom);
            min_len = ETH_HDR_LEN + 4 * ihl + TCP_HDR_LEN;
            len     = min_len + (($urandom_range(0, 7) != 0) ? $urandom_range(0, 10)
                                                             : $urandom_range(0, 300));
            // a quarter of the frames break one rule
            if ($urandom_range(0, 3) == 0) begin
               case ($urandom_range(0, 4))
                  0: etype = 16'($urandom);
                  1: proto = 8'($urandom);
                  2: vihl[3:0] = 4'($urandom_range(0, 4));
                  3: len = $urandom_range(1, min_len - 1);
                  default: flags = 8'($urandom) &
                                   ~(($urandom_range(0, 1) != 0) ? 8'h02 : 8'h10);
               endcase
            end
            send_frame(etype, vihl, proto, flags, addr, port, len,
                       $urandom_range(0, 9) == 0, rnd_entry, 1'b0, VERDICT_NONE);
            random_frames++;
         end
      end
      req_valid <= 1'b0;

      // drain the chain, then give stray results a chance to show up
      wait_cycles = 0;
      while (expected_verdicts.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (CHAIN_LATENCY + 20) @(posedge clock);
      if (expected_verdicts.size() != 0)
         report_mismatch($sformatf("%0d verdicts never arrived", expected_verdicts.size()));

      $display("summary: %0d items, %0d table writes, %0d verdicts (none %0d, passed %0d, %s",
               items_sent, entries_sent, results_seen, verdict_tally[0], verdict_tally[1],
               $sformatf("blocked %0d)", verdict_tally[2]));
      $display("summary: input held off %0d cycles by a stalled output; %0d mismatches",
               input_stalls, mismatch_count);
      if (mismatch_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
